// ===== src/sdsp_pkg.sv =====
// shared types and constants for the segment descriptor slot pool
package sdsp_pkg;

    localparam logic       CMD_ALLOC     = 1'b0;
    localparam logic       CMD_FREE      = 1'b1;

    localparam logic [1:0] STATUS_ALLOC  = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_FREED  = 2'd2;

    localparam logic [31:0] DEFAULT_LIMIT = 32'h000F_FFFF;
    localparam logic [7:0]  ACCESS_BYTE   = 8'hF2;
    localparam logic [3:0]  FLAG_NIBBLE   = 4'hC;
    localparam logic [15:0] SEL_FIRST     = 16'h0040;
    // lowest selector that still truncates to slot zero
    localparam logic [15:0] SEL_ROUND_LO  = 16'h0039;

    typedef struct packed {
        logic        cmd;
        logic [31:0] seg_base;
        logic [31:0] seg_limit;
        logic [15:0] free_selector;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_selector;
        logic [63:0] descriptor;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic drain;
    } ctl_cmd_t;

    typedef struct packed {
        logic result_held;
    } ctl_stat_t;

endpackage

// ===== src/sdsp_ctrl.sv =====
// handshake controller: owns the result register's valid state
module sdsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sdsp_pkg::ctl_cmd_t  ctl_cmd,
    input  sdsp_pkg::ctl_stat_t ctl_stat
);
    import sdsp_pkg::*;

    typedef enum logic {
        ST_EMPTY,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // the result register may be refilled in the same cycle it drains
    assign req_stall    = (state_reg == ST_HOLD) && rsp_stall;
    assign accept       = req_valid && !req_stall;
    assign rsp_valid    = (state_reg == ST_HOLD);
    assign ctl_cmd      = '{load: accept, drain: rsp_valid && !rsp_stall};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!rsp_stall && !accept)
                    state_next = ST_EMPTY;
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted beat produced no result");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> req_stall)
        else $error("input taken while result is stuck");

    a_datapath_agrees: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid == ctl_stat.result_held)
        else $error("datapath and controller disagree on held result");

endmodule

// ===== src/sdsp_datapath.sv =====
// slot bitmap, first-free search, descriptor build and result register
module sdsp_datapath #(
    parameter int POOL_SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sdsp_pkg::req_t      req,
    output sdsp_pkg::rsp_t      rsp,
    input  sdsp_pkg::ctl_cmd_t  ctl_cmd,
    output sdsp_pkg::ctl_stat_t ctl_stat
);
    import sdsp_pkg::*;

    localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

    logic [POOL_SLOTS-1:0] used_reg;
    logic [POOL_SLOTS-1:0] used_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic                  held_reg;

    logic [IDX_W-1:0] free_idx;
    logic             have_free;
    logic [31:0]      lim_src;
    logic [19:0]      lim;
    logic [63:0]      desc;
    logic [15:0]      sel_off;
    logic [12:0]      rel_idx;
    logic             rel_hit;
    logic [7:0]       alloc_sel;

    // lowest clear bit of the bitmap
    always_comb
    begin
        free_idx  = '0;
        have_free = 1'b0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx  = IDX_W'(i);
                have_free = 1'b1;
            end
        end
    end

    assign lim_src = (req.seg_limit == '0) ? DEFAULT_LIMIT : req.seg_limit;
    assign lim     = lim_src[31:12];
    assign desc    = {req.seg_base[31:24], FLAG_NIBBLE, lim[19:16], ACCESS_BYTE,
                      req.seg_base[23:0], lim[15:0]};

    assign alloc_sel = 8'(SEL_FIRST) + 8'({free_idx, 3'b000});

    // truncating division: selectors just under the first one still name slot zero
    assign sel_off = req.free_selector - SEL_FIRST;
    always_comb
    begin
        rel_idx = '0;
        rel_hit = 1'b0;
        if (req.free_selector >= SEL_FIRST)
        begin
            rel_idx = sel_off[15:3];
            rel_hit = 1'b1;
        end
        else if (req.free_selector >= SEL_ROUND_LO)
        begin
            rel_idx = '0;
            rel_hit = 1'b1;
        end
        if (rel_idx >= 13'(POOL_SLOTS))
            rel_hit = 1'b0;
    end

    always_comb
    begin
        used_next = used_reg;
        rsp_next  = '0;
        if (req.cmd == CMD_ALLOC)
        begin
            if (have_free)
            begin
                used_next[free_idx]   = 1'b1;
                rsp_next.status       = STATUS_ALLOC;
                rsp_next.out_selector = alloc_sel;
                rsp_next.descriptor   = desc;
            end
            else
            begin
                rsp_next.status = STATUS_FULL;
            end
        end
        else
        begin
            if (rel_hit)
                used_next[rel_idx[IDX_W-1:0]] = 1'b0;
            rsp_next.status = STATUS_FREED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            held_reg <= 1'b0;
        end
        else if (ctl_cmd.load)
        begin
            used_reg <= used_next;
            held_reg <= 1'b1;
        end
        else if (ctl_cmd.drain)
        begin
            held_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_reg <= '0;
        else if (ctl_cmd.load)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;
    assign ctl_stat.result_held = held_reg;

endmodule

// ===== src/segment_descriptor_slot_pool_top.sv =====
// segment descriptor slot pool: allocate and free x86 data-segment slots
// an accepted request beat is registered, and its response beat is valid in the next cycle
// throughput: one request beat per cycle while the response is not stalled; the bitmap updates as each beat is taken
// the response register may drain and refill in the same cycle
// reset: rst_n clears the slot bitmap (all slots free) and the response valid
module segment_descriptor_slot_pool_top #(
    parameter int POOL_SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sdsp_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sdsp_pkg::rsp_t rsp
);
    import sdsp_pkg::*;

    ctl_cmd_t  ctl_cmd;
    ctl_stat_t ctl_stat;

    sdsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl_cmd   (ctl_cmd),
        .ctl_stat  (ctl_stat)
    );

    sdsp_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .ctl_cmd  (ctl_cmd),
        .ctl_stat (ctl_stat)
    );

endmodule
